### rtl/core/cg3_pkg.sv
// Shared constants for the correlated 3-D Gaussian sampler.
`timescale 1ns / 1ps
package cg3_pkg;
    localparam int AddrW = 6;
    localparam logic [AddrW-1:0] AddrVarX  = 6'd0;
    localparam logic [AddrW-1:0] AddrCovXy = 6'd8;
    localparam logic [AddrW-1:0] AddrCovXz = 6'd16;
    localparam logic [AddrW-1:0] AddrVarY  = 6'd24;
    localparam logic [AddrW-1:0] AddrCovYz = 6'd32;
    localparam logic [AddrW-1:0] AddrVarZ  = 6'd40;
    localparam logic [AddrW-1:0] AddrMean  = 6'd48;
endpackage

### rtl/core/correlated_gaussian_3d.sv
// Top level: configuration registers, factor sequencer and sample datapath.
//
//  channel | ports                        | direction
//  s_      | s_valid/s_ready, normal_a..c  | in
//  m_      | m_valid/m_ready, sample_x..z  | out
//  apb     | psel..prdata                  | in/out
//
// Once the factor is cached, a sample runs through the accept state, seven
// multiply and accumulate steps on the shared 32x32 multiplier and the output state.
// After a configuration write the first sample also runs the factor build: three
// 64-bit square roots and three signed divisions on one shared bit-serial unit,
// plus the products on the shared multiplier.
// Reset is synchronous; s_ready is low while an item is in work or its result waits.
`timescale 1ns / 1ps
module correlated_gaussian_3d (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_normal_a,
    input  logic [15:0] s_normal_b,
    input  logic [15:0] s_normal_c,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sample_x,
    output logic [15:0] m_sample_y,
    output logic [15:0] m_sample_z,
    output logic        m_last_out,
    output logic        m_not_pos_def,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [cg3_pkg::AddrW-1:0] paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cg3_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_L11, S_L11W, S_D21, S_D21W, S_D31, S_D31W, S_P1, S_P2, S_D2,
        S_L22, S_L22W, S_P3, S_D32, S_D32W, S_P4, S_D3, S_P5, S_D3B, S_L33, S_L33W,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {OP_NONE, OP_SQRT, OP_DIV} op_t;

    state_t state_reg;
    logic [30:0] var_x_reg, var_y_reg, var_z_reg;
    logic [31:0] cov_xy_reg, cov_xz_reg, cov_yz_reg;
    logic [47:0] mean_reg;
    logic signed [31:0] l11_reg, l21_reg, l22_reg, l31_reg, l32_reg, l33_reg;
    logic valid_reg, bad_reg;
    logic signed [15:0] a_reg, b_reg, c_reg;
    logic last_reg;
    logic signed [63:0] acc_reg, prod_reg, d_reg;
    logic [15:0] ox_reg, oy_reg, oz_reg;

    // shared bit-serial unit: sqrt (restoring) or unsigned divide
    op_t op_reg;
    logic [6:0] cnt_reg;
    logic [63:0] rem_reg, quo_reg, num_reg;
    logic [33:0] root_reg;
    logic [31:0] den_reg;
    logic neg_reg;

    logic wr;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr)
            AddrVarX:  prdata = {33'd0, var_x_reg};
            AddrCovXy: prdata = {32'd0, cov_xy_reg};
            AddrCovXz: prdata = {32'd0, cov_xz_reg};
            AddrVarY:  prdata = {33'd0, var_y_reg};
            AddrCovYz: prdata = {32'd0, cov_yz_reg};
            AddrVarZ:  prdata = {33'd0, var_z_reg};
            AddrMean:  prdata = {16'd0, mean_reg};
            default:   prdata = 64'd0;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_sample_x = ox_reg;
    assign m_sample_y = oy_reg;
    assign m_sample_z = oz_reg;
    assign m_last_out = last_reg;
    assign m_not_pos_def = bad_reg;

    // shared multiplier; the product is registered into prod_reg at the next clock edge
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;
    always_comb begin
        case (state_reg)
            S_P1, S_P2: begin mul_a = l21_reg; mul_b = l21_reg; end
            S_P3:    begin mul_a = l31_reg; mul_b = l21_reg; end
            S_P4:    begin mul_a = l31_reg; mul_b = l31_reg; end
            S_P5, S_D3: begin mul_a = l32_reg; mul_b = l32_reg; end
            S_M0:    begin mul_a = 32'(a_reg); mul_b = l11_reg; end
            S_M1:    begin mul_a = 32'(a_reg); mul_b = l21_reg; end
            S_M2:    begin mul_a = 32'(b_reg); mul_b = l22_reg; end
            S_M3:    begin mul_a = 32'(a_reg); mul_b = l31_reg; end
            S_M4:    begin mul_a = 32'(b_reg); mul_b = l32_reg; end
            S_M5:    begin mul_a = 32'(c_reg); mul_b = l33_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // round and saturate to Q8.8
    function automatic logic [15:0] q88(input logic signed [63:0] acc,
                                        input logic [15:0] m);
        logic signed [63:0] t;
        logic signed [43:0] q;
        t = acc + {{28{m[15]}}, m, 20'd0} + 64'sd524288;
        q = t[63:20];
        if (q > 44'sd32767) return 16'h7fff;
        if (q < -44'sd32768) return 16'h8000;
        return q[15:0];
    endfunction

    // signed dividend, magnitude into the unit
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic big(input logic signed [63:0] v);
        return (v >= 64'sh80000000) || (v <= -64'sh80000000);
    endfunction

    logic unit_busy;
    assign unit_busy = (op_reg != OP_NONE);
    logic signed [63:0] quo_s;
    assign quo_s = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    logic [65:0] sq_trial;
    logic [64:0] dv_trial;
    assign sq_trial = {rem_reg, num_reg[63:62]} - {30'd0, root_reg, 2'b01};
    assign dv_trial = {rem_reg, num_reg[63]} - {33'd0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= OP_NONE;
            var_x_reg <= 31'd65536; var_y_reg <= 31'd65536; var_z_reg <= 31'd65536;
            cov_xy_reg <= '0; cov_xz_reg <= '0; cov_yz_reg <= '0;
            mean_reg <= '0;
            valid_reg <= 1'b0; bad_reg <= 1'b0;
            l11_reg <= '0; l21_reg <= '0; l22_reg <= '0;
            l31_reg <= '0; l32_reg <= '0; l33_reg <= '0;
        end else begin
            if (wr) begin
                case (paddr)
                    AddrVarX:  begin var_x_reg <= pwdata[30:0]; valid_reg <= 1'b0; end
                    AddrCovXy: begin cov_xy_reg <= pwdata[31:0]; valid_reg <= 1'b0; end
                    AddrCovXz: begin cov_xz_reg <= pwdata[31:0]; valid_reg <= 1'b0; end
                    AddrVarY:  begin var_y_reg <= pwdata[30:0]; valid_reg <= 1'b0; end
                    AddrCovYz: begin cov_yz_reg <= pwdata[31:0]; valid_reg <= 1'b0; end
                    AddrVarZ:  begin var_z_reg <= pwdata[30:0]; valid_reg <= 1'b0; end
                    AddrMean:  begin mean_reg <= pwdata[47:0]; valid_reg <= 1'b0; end
                    default: ;
                endcase
            end
            // bit-serial step
            if (op_reg == OP_SQRT) begin
                if (!sq_trial[65]) begin
                    rem_reg <= sq_trial[63:0];
                    root_reg <= {root_reg[32:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[61:0], num_reg[63:62]};
                    root_reg <= {root_reg[32:0], 1'b0};
                end
                num_reg <= {num_reg[61:0], 2'b00};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) op_reg <= OP_NONE;
            end else if (op_reg == OP_DIV) begin
                if (!dv_trial[64]) begin
                    rem_reg <= dv_trial[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[62:0], num_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                num_reg <= {num_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) op_reg <= OP_NONE;
            end
            prod_reg <= mul_p;
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    a_reg <= $signed(s_normal_a); b_reg <= $signed(s_normal_b);
                    c_reg <= $signed(s_normal_c); last_reg <= s_last_in;
                    if (valid_reg) state_reg <= S_M0;
                    else if (var_x_reg == 31'd0) state_reg <= S_FIN;
                    else begin
                        bad_reg <= 1'b0;
                        op_reg <= OP_SQRT; cnt_reg <= 7'd32;
                        rem_reg <= '0; root_reg <= '0;
                        num_reg <= {17'd0, var_x_reg, 16'd0};
                        state_reg <= S_L11;
                    end
                end
                S_L11: state_reg <= S_L11W;
                S_L11W: if (!unit_busy) begin
                    l11_reg <= $signed(root_reg[31:0]);
                    op_reg <= OP_DIV; cnt_reg <= 7'd64; rem_reg <= '0; quo_reg <= '0;
                    den_reg <= root_reg[31:0];
                    num_reg <= mag({{16{cov_xy_reg[31]}}, cov_xy_reg, 16'd0});
                    neg_reg <= cov_xy_reg[31];
                    state_reg <= S_D21;
                end
                S_D21: state_reg <= S_D21W;
                S_D21W: if (!unit_busy) begin
                    if (big(quo_s)) state_reg <= S_FIN;
                    else begin
                        l21_reg <= quo_s[31:0];
                        op_reg <= OP_DIV; cnt_reg <= 7'd64; rem_reg <= '0; quo_reg <= '0;
                        num_reg <= mag({{16{cov_xz_reg[31]}}, cov_xz_reg, 16'd0});
                        neg_reg <= cov_xz_reg[31];
                        state_reg <= S_D31;
                    end
                end
                S_D31: state_reg <= S_D31W;
                S_D31W: if (!unit_busy) begin
                    if (big(quo_s)) state_reg <= S_FIN;
                    else begin
                        l31_reg <= quo_s[31:0];
                        state_reg <= S_P1;
                    end
                end
                S_P1: state_reg <= S_P2;
                S_P2: state_reg <= S_D2;
                S_D2: begin
                    d_reg <= $signed({17'd0, var_y_reg, 16'd0}) - prod_reg;
                    state_reg <= S_L22;
                end
                S_L22: if (d_reg <= 0) state_reg <= S_FIN;
                else begin
                    op_reg <= OP_SQRT; cnt_reg <= 7'd32; rem_reg <= '0; root_reg <= '0;
                    num_reg <= d_reg; state_reg <= S_L22W;
                end
                S_L22W: if (!unit_busy) begin
                    l22_reg <= $signed(root_reg[31:0]);
                    den_reg <= root_reg[31:0];
                    state_reg <= S_P3;
                end
                S_P3: state_reg <= S_D32;
                S_D32: begin
                    op_reg <= OP_DIV; cnt_reg <= 7'd64; rem_reg <= '0; quo_reg <= '0;
                    num_reg <= mag($signed({{16{cov_yz_reg[31]}}, cov_yz_reg, 16'd0})
                                   - prod_reg);
                    neg_reg <= ($signed({{16{cov_yz_reg[31]}}, cov_yz_reg, 16'd0})
                                - prod_reg) < 0;
                    state_reg <= S_D32W;
                end
                S_D32W: if (!unit_busy && cnt_reg == 7'd0) begin
                    if (big(quo_s)) state_reg <= S_FIN;
                    else begin
                        l32_reg <= quo_s[31:0];
                        state_reg <= S_P4;
                    end
                end
                S_P4: state_reg <= S_P5;
                S_P5: begin
                    d_reg <= $signed({17'd0, var_z_reg, 16'd0}) - prod_reg;
                    state_reg <= S_D3;
                end
                S_D3: state_reg <= S_D3B;
                S_D3B: begin
                    d_reg <= d_reg - prod_reg;
                    state_reg <= S_L33;
                end
                S_L33: if (d_reg <= 0) state_reg <= S_FIN;
                else begin
                    op_reg <= OP_SQRT; cnt_reg <= 7'd32; rem_reg <= '0; root_reg <= '0;
                    num_reg <= d_reg; state_reg <= S_L33W;
                end
                S_L33W: if (!unit_busy) begin
                    l33_reg <= $signed(root_reg[31:0]);
                    valid_reg <= 1'b1;
                    state_reg <= S_M0;
                end
                // bad covariance: clear factor and emit zeros
                S_FIN: begin
                    l11_reg <= '0; l21_reg <= '0; l22_reg <= '0;
                    l31_reg <= '0; l32_reg <= '0; l33_reg <= '0;
                    bad_reg <= 1'b1; valid_reg <= 1'b1;
                    ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_M0: state_reg <= S_M1;
                S_M1: begin
                    ox_reg <= bad_reg ? 16'd0 : q88(prod_reg, mean_reg[15:0]);
                    state_reg <= S_M2;
                end
                S_M2: begin
                    acc_reg <= prod_reg; state_reg <= S_M3;
                end
                S_M3: begin
                    oy_reg <= bad_reg ? 16'd0 : q88(acc_reg + prod_reg, mean_reg[31:16]);
                    state_reg <= S_M4;
                end
                S_M4: begin
                    acc_reg <= prod_reg; state_reg <= S_M5;
                end
                S_M5: begin
                    acc_reg <= acc_reg + prod_reg;
                    state_reg <= S_M6;
                end
                S_M6: begin
                    oz_reg <= bad_reg ? 16'd0 : q88(acc_reg + prod_reg, mean_reg[47:32]);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/cg3_checker.sv
// Port-level checks for the correlated 3-D Gaussian sampler.
`timescale 1ns / 1ps
module cg3_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_not_pos_def,
    input logic [15:0] m_sample_x
);
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready after accept");
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_not_pos_def) |-> m_sample_x == 16'd0) else $error("bad nonzero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
endmodule

bind correlated_gaussian_3d cg3_checker u_cg3_checker (.*);

### tb/correlated_gaussian_3d_tb.sv
// Self-checking testbench for the correlated 3-D Gaussian sampler.
`timescale 1ns / 1ps
module correlated_gaussian_3d_tb;
    import cg3_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_normal_a = '0, s_normal_b = '0, s_normal_c = '0;
    logic        s_last_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_sample_x, m_sample_y, m_sample_z;
    logic        m_last_out, m_not_pos_def;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [15:0] x, y, z;
        logic        last, bad;
    } sample_t;

    correlated_gaussian_3d dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the configuration and the cached factor
    longint sh_vx, sh_cxy, sh_cxz, sh_vy, sh_cyz, sh_vz;
    logic [47:0] sh_mean;
    longint f11, f21, f22, f31, f32, f33;
    bit     f_ok, f_bad;

    sample_t expected_samples[$];
    int      mismatches, samples_seen, bad_seen, sent, idle_cycles;
    bit      stall_on;

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, bits;
        r = 0;
        bits = 64'd1 << 62;
        while (bits > v) bits >>= 2;
        while (bits != 0) begin
            if (v >= r + bits) begin
                v -= r + bits;
                r = (r >> 1) + bits;
            end else begin
                r >>= 1;
            end
            bits >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic bit oversized(longint v);
        return v >= 64'sd2147483648 || v <= -64'sd2147483648;
    endfunction

    task automatic factorize();
        longint l11, l21, l22, l31, l32, l33, d;
        bit bad;
        l11 = 0; l21 = 0; l22 = 0; l31 = 0; l32 = 0; l33 = 0;
        bad = (sh_vx == 0);
        if (!bad) begin
            l11 = int_sqrt(longint'(sh_vx) << 16);
            l21 = (sh_cxy * 65536) / l11;
            l31 = (sh_cxz * 65536) / l11;
            bad = oversized(l21) || oversized(l31);
        end
        if (!bad) begin
            d = sh_vy * 65536 - l21 * l21;
            if (d <= 0) bad = 1;
            else l22 = int_sqrt(d);
        end
        if (!bad) begin
            l32 = (sh_cyz * 65536 - l31 * l21) / l22;
            bad = oversized(l32);
        end
        if (!bad) begin
            d = sh_vz * 65536 - l31 * l31 - l32 * l32;
            if (d <= 0) bad = 1;
            else l33 = int_sqrt(d);
        end
        if (bad) begin
            l11 = 0; l21 = 0; l22 = 0; l31 = 0; l32 = 0; l33 = 0;
        end
        f11 = l11; f21 = l21; f22 = l22; f31 = l31; f32 = l32; f33 = l33;
        f_bad = bad;
        f_ok = 1;
    endtask

    function automatic logic [15:0] round_q88(longint acc, longint m);
        longint t, q;
        t = acc + m * 1048576 + 524288;
        if (t >= 0) q = t / 1048576;
        else q = -((-t + 1048575) / 1048576);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic sample_t predict_sample(logic [15:0] na, logic [15:0] nb,
                                               logic [15:0] nc, logic lst);
        sample_t r;
        longint a, b, c;
        a = longint'($signed(na));
        b = longint'($signed(nb));
        c = longint'($signed(nc));
        if (f_bad) begin
            r.x = '0; r.y = '0; r.z = '0;
        end else begin
            r.x = round_q88(a * f11, longint'($signed(sh_mean[15:0])));
            r.y = round_q88(a * f21 + b * f22, longint'($signed(sh_mean[31:16])));
            r.z = round_q88(a * f31 + b * f32 + c * f33,
                            longint'($signed(sh_mean[47:32])));
        end
        r.last = lst;
        r.bad = f_bad;
        return r;
    endfunction

    task automatic send_sample(logic [15:0] na, logic [15:0] nb, logic [15:0] nc,
                               logic lst);
        if (!f_ok) factorize();
        expected_samples.push_back(predict_sample(na, nb, nc, lst));
        s_valid <= 1'b1;
        s_normal_a <= na;
        s_normal_b <= nb;
        s_normal_c <= nc;
        s_last_in <= lst;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(int idx, logic [63:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AddrW'(idx * 8); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            0: sh_vx = longint'(value[30:0]);
            1: sh_cxy = longint'($signed(value[31:0]));
            2: sh_cxz = longint'($signed(value[31:0]));
            3: sh_vy = longint'(value[30:0]);
            4: sh_cyz = longint'($signed(value[31:0]));
            5: sh_vz = longint'(value[30:0]);
            6: sh_mean = value[47:0];
            default: ;
        endcase
        if (idx <= 6) f_ok = 0;
        @(posedge aclk);
    endtask

    task automatic set_cov(longint vx, longint cxy, longint cxz, longint vy,
                           longint cyz, longint vz, logic [47:0] mean);
        drain();
        write_reg(0, 64'(vx)); write_reg(1, 64'(cxy)); write_reg(2, 64'(cxz));
        write_reg(3, 64'(vy)); write_reg(4, 64'(cyz)); write_reg(5, 64'(vz));
        write_reg(6, 64'(mean));
    endtask

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 16384)) - 8192);
        endcase
    endfunction

    task automatic random_burst(int count);
        int left;
        left = count;
        while (left > 0) begin
            repeat ($urandom_range(1, 12)) begin
                if (left > 0) begin
                    send_sample(rand_normal(), rand_normal(), rand_normal(),
                                1'($urandom));
                    left--;
                end
            end
            repeat ($urandom_range(0, 4)) idle_sender();
        end
    endtask

    task automatic test_edges();
        logic [15:0] v[4];
        v[0] = 16'h8000; v[1] = 16'h7fff; v[2] = 16'h0000; v[3] = 16'hffff;
        for (int i = 0; i < 4; i++) send_sample(v[i], v[3 - i], v[i], i[0]);
        send_sample(16'h1000, 16'h1000, 16'h1000, 1'b1);
    endtask

    task automatic test_bad_covariances();
        set_cov(0, 0, 0, 65536, 0, 65536, 48'h0100_0100_0100);
        send_sample(16'h1000, 16'h0800, 16'hf000, 1'b1);
        set_cov(65536, 65536, 0, 65536, 0, 65536, 0);
        send_sample(16'h1000, 16'h1000, 16'h1000, 1'b0);
        set_cov(65536, 0, 0, 65536, 65536, 65536, 0);
        send_sample(16'h1000, 16'h1000, 16'h1000, 1'b0);
        set_cov(1, 32'h7fffffff, 0, 32'h7fffffff, 0, 32'h7fffffff, 0);
        send_sample(16'h1000, 16'h1000, 16'h1000, 1'b0);
        set_cov(1, 0, 0, 1, 32'h80000000, 1, 0);
        send_sample(16'h1000, 16'h1000, 16'h1000, 1'b0);
    endtask

    task automatic test_extreme_config();
        set_cov(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                32'h00000000, 32'h7fffffff, 48'hffff_ffff_ffff);
        test_edges();
        set_cov(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 32'h7fffffff, 48'h8000_7fff_8000);
        test_edges();
        set_cov(65536, 32768, -16384, 131072, 8192, 98304, 48'h0080_ff00_0200);
        test_edges();
        // out-of-range register index keeps the cached factor
        drain();
        write_reg(7, 64'hdead_beef);
        send_sample(16'h2000, 16'he000, 16'h1000, 1'b1);
    endtask

    task automatic test_random();
        longint vx, vy, vz;
        for (int phase = 0; phase < 12; phase++) begin
            vx = $urandom_range(1, 1 << 20);
            vy = $urandom_range(1, 1 << 20);
            vz = $urandom_range(1, 1 << 20);
            // mostly positive definite: off-diagonals kept small
            if ($urandom_range(0, 4) == 0)
                set_cov(31'($urandom), 32'($urandom), 32'($urandom), 31'($urandom),
                        32'($urandom), 31'($urandom), 48'({$urandom, $urandom}));
            else
                set_cov(vx, $signed($urandom_range(0, 32'(vx / 2))) - vx / 4,
                        $signed($urandom_range(0, 32'(vx / 2))) - vx / 4, vy,
                        $signed($urandom_range(0, 32'(vy / 4))) - vy / 8, vz,
                        48'({$urandom, $urandom}));
            random_burst(85);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        sample_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_sample_x, m_sample_y, m_sample_z, m_last_out, m_not_pos_def};
            samples_seen++;
            if (m_not_pos_def) bad_seen++;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %h", got);
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: exp %h %h %h %b %b got %h %h %h %b %b",
                                 samples_seen, want.x, want.y, want.z, want.last, want.bad,
                                 got.x, got.y, got.z, got.last, got.bad);
                end
            end
        end
    end

    // receiver stall pattern: stretches of free flow and of random stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        m_ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // watchdog on cycles with no accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        sh_vx = 65536; sh_vy = 65536; sh_vz = 65536;
        sh_cxy = 0; sh_cxz = 0; sh_cyz = 0; sh_mean = '0;
        f_ok = 0; f_bad = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edges();
        test_bad_covariances();
        test_extreme_config();
        test_random();
        drain();
        $display("covered %0d samples across reset, extreme, singular and random covariances",
                 sent);
        $display("%0d results checked, %0d flagged not positive definite",
                 samples_seen, bad_seen);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
